FILE: rtl/core/sync_length_xor_frame_parser_top_assert.svh
// ----------------------------------------------------------------------------
// sync length xor frame parser assertion macros
// shared forms for the concurrent checks on the parser ports
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_TOP_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define SLFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// constants and types shared by the sync length xor frame parser
// ----------------------------------------------------------------------------
package slfp_pkg;

	localparam logic [7:0] SYNC_U     = 8'h55;
	localparam logic [7:0] SYNC_N     = 8'h4E;
	localparam logic [7:0] SYNC_E     = 8'h45;
	localparam logic [7:0] SYNC_R     = 8'h52;
	localparam logic [7:0] SYNC_COLON = 8'h3A;

	localparam logic [2:0] PH_HUNT_U  = 3'd0;
	localparam logic [2:0] PH_WANT_N  = 3'd1;
	localparam logic [2:0] PH_WANT_E  = 3'd2;
	localparam logic [2:0] PH_WANT_R  = 3'd3;
	localparam logic [2:0] PH_LEN_LO  = 3'd4;
	localparam logic [2:0] PH_LEN_HI  = 3'd5;
	localparam logic [2:0] PH_COLON   = 3'd6;
	localparam logic [2:0] PH_PAYLOAD = 3'd7;

	typedef struct packed {
		logic       emit;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_length;
		logic       last;
		logic       checksum_ok;
	} slfp_result_t;

endpackage

FILE: rtl/core/slfp_in_if.sv
// ----------------------------------------------------------------------------
// slfp_in_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface slfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/slfp_out_if.sv
// ----------------------------------------------------------------------------
// slfp_out_if
// parsed byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface slfp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] frame_length;
	logic       last;
	logic       checksum_ok;

	modport source (output valid, output payload_byte, output payload_index,
		output frame_length, output last, output checksum_ok, input ready);
	modport sink (input valid, input payload_byte, input payload_index,
		input frame_length, input last, input checksum_ok, output ready);
endinterface

FILE: rtl/core/slfp_parser.sv
// ----------------------------------------------------------------------------
// slfp_parser
// frame state tracker: sync hunt, header, payload count and running xor
// ----------------------------------------------------------------------------
module slfp_parser
	import slfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic [7:0]   rx_byte,
	output slfp_result_t res
);

	logic [2:0] phase_q, phase_d;
	logic [7:0] remain_q, remain_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] length_q, length_d;
	logic [7:0] pos_q, pos_d;
	logic [7:0] xor_in;

	assign xor_in = xor_q ^ rx_byte;

	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		xor_d    = xor_q;
		length_d = length_q;
		pos_d    = pos_q;

		res.emit          = 1'b0;
		res.payload_byte  = rx_byte;
		res.payload_index = 8'd0;
		res.frame_length  = length_q;
		res.last          = 1'b0;
		res.checksum_ok   = 1'b0;

		case (phase_q)
			PH_HUNT_U: begin
				if (rx_byte == SYNC_U) begin
					phase_d = PH_WANT_N;
					xor_d   = SYNC_U;
				end
			end
			PH_WANT_N, PH_WANT_E, PH_WANT_R, PH_COLON: begin
				if ((phase_q == PH_WANT_N && rx_byte == SYNC_N) ||
				    (phase_q == PH_WANT_E && rx_byte == SYNC_E) ||
				    (phase_q == PH_WANT_R && rx_byte == SYNC_R) ||
				    (phase_q == PH_COLON && rx_byte == SYNC_COLON)) begin
					xor_d   = xor_in;
					phase_d = phase_q + 3'd1;
					if (phase_q == PH_COLON) begin
						remain_d = length_q - 8'd1;
						pos_d    = 8'd0;
					end
				end else if (rx_byte == SYNC_U) begin
					phase_d = PH_WANT_N;
					xor_d   = SYNC_U;
				end else begin
					phase_d = PH_HUNT_U;
				end
			end
			PH_LEN_LO: begin
				length_d = rx_byte;
				xor_d    = xor_in;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				xor_d   = xor_in;
				phase_d = PH_COLON;
			end
			PH_PAYLOAD: begin
				res.emit = 1'b1;
				if (remain_q != 8'd0) begin
					xor_d             = xor_in;
					remain_d          = remain_q - 8'd1;
					pos_d             = pos_q + 8'd1;
					res.payload_index = pos_q + 8'd1;
				end else begin
					res.last        = 1'b1;
					res.checksum_ok = (rx_byte == xor_q);
					phase_d         = PH_HUNT_U;
				end
			end
			default: begin
				phase_d = PH_HUNT_U;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT_U;
			remain_q <= 8'd0;
			xor_q    <= 8'd0;
			length_q <= 8'd0;
			pos_q    <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			xor_q    <= xor_d;
			length_q <= length_d;
			pos_q    <= pos_d;
		end
	end

endmodule

FILE: rtl/core/sync_length_xor_frame_parser_top.sv
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser_top
// Takes one received byte per beat, finds frames that open with the four
// sync bytes 'U' 'N' 'E' 'R', a length low and high byte and ':', then
// passes length-1 payload bytes (a length of zero means 255) and closes with
// an xor checksum beat marked last, with checksum_ok telling pass or fail.
// Header bytes give no output beat. A byte can be taken on every clock while
// input is open, which it is while the single output register is empty or
// being drained; its result appears there in the cycle after acceptance.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_parser_top
	import slfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	slfp_in_if.sink           ingress,
	slfp_out_if.source        egress
);

	slfp_result_t res;
	logic         accept;
	logic         out_valid_s1;
	logic [7:0]   byte_s1;
	logic [7:0]   index_s1;
	logic [7:0]   length_s1;
	logic         last_s1;
	logic         ok_s1;

	assign ingress.ready = !out_valid_s1 || egress.ready;
	assign accept        = ingress.valid && ingress.ready;

	slfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.rx_byte (ingress.rx_byte),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= res.emit;
		end else if (egress.ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.emit) begin
			byte_s1   <= res.payload_byte;
			index_s1  <= res.payload_index;
			length_s1 <= res.frame_length;
			last_s1   <= res.last;
			ok_s1     <= res.checksum_ok;
		end
	end

	assign egress.valid         = out_valid_s1;
	assign egress.payload_byte  = byte_s1;
	assign egress.payload_index = index_s1;
	assign egress.frame_length  = length_s1;
	assign egress.last          = last_s1;
	assign egress.checksum_ok   = ok_s1;

endmodule

FILE: rtl/core/slfp_checker.sv
// ----------------------------------------------------------------------------
// slfp_checker
// port-level checks for the frame parser, bound to the top level
// ----------------------------------------------------------------------------
`include "sync_length_xor_frame_parser_top_assert.svh"

module slfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] payload_byte,
	input logic [7:0] payload_index,
	input logic       last,
	input logic       checksum_ok
);

	`SLFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(payload_byte) && $stable(payload_index) && $stable(last),
		"stalled output beat changed")

	`SLFP_ASSERT_NOW(a_last_index, clk, arst_n, out_valid && last,
		payload_index == 8'd0, "checksum beat carries a payload index")

	`SLFP_ASSERT_NOW(a_payload_fields, clk, arst_n, out_valid && !last,
		payload_index != 8'd0 && !checksum_ok, "payload beat has bad index or flag")

	`SLFP_ASSERT_NEXT(a_new_beat_from_input, clk, arst_n,
		!(in_valid && in_ready) && !(out_valid && !out_ready),
		!out_valid, "output beat without an accepted byte")

endmodule

bind sync_length_xor_frame_parser_top slfp_checker u_slfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (ingress.valid),
	.in_ready      (ingress.ready),
	.out_valid     (egress.valid),
	.out_ready     (egress.ready),
	.payload_byte  (egress.payload_byte),
	.payload_index (egress.payload_index),
	.last          (egress.last),
	.checksum_ok   (egress.checksum_ok)
);
